// File: rtl/core/assert_macros.svh
// Assertion macros shared by the decoder RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UFC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UFC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ufc_pkg.sv
// Package with the shared types, constants and case-fold function of the decoder.
`timescale 1ns / 1ps

package ufc_pkg;

  localparam int unsigned CodeW   = 21;
  localparam int unsigned FoldW   = 11;

  localparam logic [CodeW-1:0] Replacement = 21'h00FFFD;
  localparam logic [7:0]       LeadMax     = 8'hF4;
  localparam logic [7:0]       LeadMin     = 8'hC0;
  localparam logic [5:0]       ContMask    = 6'h3F;

  // One accepted byte expands into a burst: some replacements, then at most
  // one closing result.
  typedef struct packed {
    logic [1:0]       reps;
    logic             tail;
    logic [CodeW-1:0] tail_code;
    logic             tail_bad;
    logic [FoldW-1:0] tail_folded;
    logic             fin;
  } ufc_job_t;

  function automatic logic [FoldW-1:0] fold_token(input logic [CodeW-1:0] c);
    logic [FoldW-1:0] lo;
    logic [FoldW-1:0] res;
    lo  = c[FoldW-1:0];
    res = '0;
    priority if (c >= 21'h61 && c <= 21'h7A) begin
      res = lo;
    end else if (c >= 21'h41 && c <= 21'h5A) begin
      res = lo + 11'h20;
    end else if (c >= 21'h30 && c <= 21'h39) begin
      res = lo;
    end else if (c < 21'h0C0) begin
      res = '0;
    end else if (c <= 21'h0FF) begin
      if (c == 21'h0D7 || c == 21'h0F7) begin
        res = '0;
      end else if (c <= 21'h0DE) begin
        res = lo + 11'h20;
      end else begin
        res = lo;
      end
    end else if (c == 21'h386) begin
      res = 11'h3AC;
    end else if (c >= 21'h388 && c <= 21'h38A) begin
      res = lo + 11'h25;
    end else if (c == 21'h38C) begin
      res = 11'h3CC;
    end else if (c == 21'h38E || c == 21'h38F) begin
      res = lo + 11'h3F;
    end else if (c >= 21'h391 && c <= 21'h3AB) begin
      res = (c == 21'h3A2) ? 11'h000 : lo + 11'h20;
    end else if (c >= 21'h3AC && c <= 21'h3CE) begin
      res = lo;
    end else if (c >= 21'h400 && c <= 21'h40F) begin
      res = lo + 11'h50;
    end else if (c >= 21'h410 && c <= 21'h42F) begin
      res = lo + 11'h20;
    end else if (c >= 21'h430 && c <= 21'h45F) begin
      res = lo;
    end else if (c >= 21'h460 && c <= 21'h481) begin
      res = c[0] ? lo : lo + 11'h001;
    end else if (c == 21'h4C0) begin
      res = 11'h4CF;
    end else if (c >= 21'h4C1 && c <= 21'h4CE) begin
      res = c[0] ? lo + 11'h001 : lo;
    end else if ((c >= 21'h48A && c <= 21'h4BF) || (c >= 21'h4CF && c <= 21'h4FF)) begin
      res = c[0] ? lo : lo + 11'h001;
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

// File: rtl/core/ufc_in_if.sv
// Interface of the byte input channel.
`timescale 1ns / 1ps

interface ufc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       final_byte;

  modport source (output valid, output byte_in, output final_byte, input ready);
  modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

// File: rtl/core/ufc_out_if.sv
// Interface of the decoded result channel.
`timescale 1ns / 1ps

interface ufc_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [10:0] folded;
  logic        malformed;
  logic        run_last;
  logic        text_end;

  modport source (output valid, output code_point, output folded, output malformed,
                  output run_last, output text_end, input ready);
  modport sink   (input valid, input code_point, input folded, input malformed,
                  input run_last, input text_end, output ready);
endinterface

// File: rtl/core/ufc_decode.sv
// Sequence state of the UTF-8 decoder and the burst descriptor for each byte.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ufc_decode
  import ufc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       final_byte,
  output ufc_job_t   job
);

  logic [CodeW-1:0] partial_code, partial_code_next;
  logic [1:0]       bytes_needed, bytes_needed_next;
  logic [1:0]       bytes_held, bytes_held_next;

  logic             is_cont;
  logic [CodeW-1:0] grown;
  logic [1:0]       needed_dec;

  always_comb begin
    is_cont    = (byte_in[7:6] == 2'b10);
    grown      = {partial_code[CodeW-7:0], byte_in[5:0] & ContMask};
    needed_dec = bytes_needed - 2'd1;

    partial_code_next = partial_code;
    bytes_needed_next = bytes_needed;
    bytes_held_next   = bytes_held;
    job               = '0;
    job.fin           = final_byte;

    if (bytes_needed != 2'd0 && is_cont) begin
      if (needed_dec == 2'd0) begin
        job.tail          = 1'b1;
        job.tail_code     = grown;
        job.tail_folded   = fold_token(grown);
        partial_code_next = '0;
        bytes_needed_next = '0;
        bytes_held_next   = '0;
      end else if (final_byte) begin
        job.reps          = bytes_held + 2'd1;
        partial_code_next = '0;
        bytes_needed_next = '0;
        bytes_held_next   = '0;
      end else begin
        partial_code_next = grown;
        bytes_needed_next = needed_dec;
        bytes_held_next   = bytes_held + 2'd1;
      end
    end else begin
      // Held bytes of a broken sequence are replaced, then the byte is a lead.
      job.reps          = (bytes_needed != 2'd0) ? bytes_held : 2'd0;
      partial_code_next = '0;
      bytes_needed_next = '0;
      bytes_held_next   = '0;
      if (!byte_in[7]) begin
        job.tail        = 1'b1;
        job.tail_code   = {13'd0, byte_in};
        job.tail_folded = fold_token({13'd0, byte_in});
      end else if (byte_in < LeadMin || byte_in > LeadMax || final_byte) begin
        job.tail      = 1'b1;
        job.tail_code = Replacement;
        job.tail_bad  = 1'b1;
      end else begin
        bytes_held_next = 2'd1;
        if (byte_in[5:4] == 2'b11) begin
          partial_code_next = {18'd0, byte_in[2:0]};
          bytes_needed_next = 2'd3;
        end else if (byte_in[5]) begin
          partial_code_next = {17'd0, byte_in[3:0]};
          bytes_needed_next = 2'd2;
        end else begin
          partial_code_next = {16'd0, byte_in[4:0]};
          bytes_needed_next = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code <= '0;
      bytes_needed <= '0;
      bytes_held   <= '0;
    end else if (accept) begin
      partial_code <= partial_code_next;
      bytes_needed <= bytes_needed_next;
      bytes_held   <= bytes_held_next;
    end
  end

  `UFC_ASSERT_IMP(a_open_seq_holds_bytes, clk, rst, bytes_needed != 2'd0, bytes_held != 2'd0, "open sequence without held bytes")
  `UFC_ASSERT_NXT(a_final_closes_seq, clk, rst, accept && final_byte, bytes_needed == 2'd0 && bytes_held == 2'd0, "sequence left open after final byte")

endmodule

// File: rtl/core/ufc_emit.sv
// Burst register and output register that issue one result per cycle unless out_stream stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ufc_emit
  import ufc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ufc_job_t      job_in,
  output logic          ready,
  ufc_out_if.source     out_stream
);

  ufc_job_t job;
  logic     job_busy;
  logic     job_last;
  logic     load;
  logic     last_load;

  assign job_busy  = (job.reps != 2'd0) || job.tail;
  assign job_last  = (job.reps == 2'd1 && !job.tail) || (job.reps == 2'd0 && job.tail);
  assign load      = job_busy && (!out_stream.valid || out_stream.ready);
  assign last_load = load && job_last;
  assign ready     = !job_busy || last_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      job.reps         <= '0;
      job.tail         <= 1'b0;
      out_stream.valid <= 1'b0;
    end else begin
      if (push) begin
        job <= job_in;
      end else if (load) begin
        if (job.reps != 2'd0) begin
          job.reps <= job.reps - 2'd1;
        end else begin
          job.tail <= 1'b0;
        end
      end

      if (load) begin
        out_stream.valid <= 1'b1;
        if (job.reps != 2'd0) begin
          out_stream.code_point <= Replacement;
          out_stream.folded     <= '0;
          out_stream.malformed  <= 1'b1;
          out_stream.run_last   <= job_last;
          out_stream.text_end   <= job_last && job.fin;
        end else begin
          out_stream.code_point <= job.tail_code;
          out_stream.folded     <= job.tail_folded;
          out_stream.malformed  <= job.tail_bad;
          out_stream.run_last   <= 1'b1;
          out_stream.text_end   <= job.fin;
        end
      end else if (out_stream.ready) begin
        out_stream.valid <= 1'b0;
      end
    end
  end

  `UFC_ASSERT_IMP(a_push_when_free, clk, rst, push, !job_busy || last_load, "burst overwritten before it was issued")
  `UFC_ASSERT_IMP(a_bad_is_replacement, clk, rst, out_stream.valid && out_stream.malformed, out_stream.folded == '0 && out_stream.code_point == Replacement, "malformed result with payload")
  `UFC_ASSERT_IMP(a_end_is_run_last, clk, rst, out_stream.valid && out_stream.text_end, out_stream.run_last, "text end not on the last result of a byte")

endmodule

// File: rtl/core/utf8_decode_case_fold_core.sv
// Top level of the UTF-8 decoder with token-forming case fold.
`timescale 1ns / 1ps

// The block takes text one byte per transfer on in_stream (byte_in, with
// final_byte set on the last byte of a text) and returns decoded code points
// on out_stream, each with its folded lower-case token form, a malformed flag,
// run_last on the last result caused by a byte and text_end on the very last
// result of the text.
// A byte is decoded as it is taken: the sequence state is updated and the
// results it causes are written as one burst into a burst register. From there
// the first result of the burst moves into the output register as soon as that
// register is free or is being emptied, and is offered on out_stream from there.
// Throughput is one byte per cycle while out_stream keeps up. A byte that
// only extends a sequence causes no result and costs nothing further; a byte
// with more than one result holds in_stream.ready low until its last result
// enters the output register, one per cycle (at most four for a broken sequence).
// When out_stream stalls, the output register holds its result and the burst
// register waits behind it; in_stream keeps taking bytes until the burst
// register is occupied by a burst that cannot drain.
// Synchronous reset closes any open sequence and empties both registers.

module utf8_decode_case_fold_core
  import ufc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ufc_in_if.sink    in_stream,
  ufc_out_if.source out_stream
);

  ufc_job_t job;
  logic     accept;
  logic     push;
  logic     ready;

  // A byte is taken whenever the burst register is free or is handing over
  // its last result in this cycle.
  assign in_stream.ready = ready;
  assign accept          = in_stream.valid && ready;

  // Only bytes that cause results occupy the burst register.
  assign push = accept && ((job.reps != 2'd0) || job.tail);

  ufc_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_in    (in_stream.byte_in),
    .final_byte (in_stream.final_byte),
    .job        (job)
  );

  ufc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .job_in     (job),
    .ready      (ready),
    .out_stream (out_stream)
  );

endmodule

// File: tb/tb_utf8_decode_case_fold_core.sv
// Self-checking testbench for the UTF-8 decoder with token-forming case fold.
`timescale 1ns / 1ps

// Raw bytes are queued by the stimulus process and offered on the byte channel
// by a clocked driver. Each byte transfer is decoded at once by a predictor
// that keeps its own copy of the sequence state. The predictor appends the
// results that the byte should cause to a queue of due results. A clocked
// monitor takes every result transfer and compares it with the oldest due
// result. Sender gaps and receiver stalls change from phase to phase. One phase
// holds the receiver off for a long stretch while bytes keep coming, so that
// the block fills up and stalls its input.

module tb_utf8_decode_case_fold_core
  import ufc_pkg::*;
();

  localparam int unsigned ClkHalf    = 10;
  localparam int unsigned ResetTicks = 11;
  localparam int unsigned TailTicks  = 8;      // two register stages plus margin
  localparam int unsigned LongHold   = 150;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned ShownFaults = 10;

  // Code points that break an otherwise regular fold range, and one fold shift.
  localparam int unsigned TimesSign   = 'h0D7;
  localparam int unsigned DivideSign  = 'h0F7;
  localparam int unsigned GreekHole   = 'h3A2;
  localparam int unsigned AlphaTonos  = 'h386;
  localparam int unsigned OmicronTonos = 'h38C;
  localparam int unsigned PalochkaUp  = 'h4C0;
  localparam int unsigned PalochkaLow = 'h4CF;
  localparam int unsigned CyrExtShift = 'h50;

  typedef struct packed {
    logic [7:0] value;
    logic       last_of_text;
  } text_byte_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [FoldW-1:0] fold;
    logic             bad;
    logic             last;
    logic             ends;
  } decoded_t;

  logic clk;
  logic rst;

  ufc_in_if  byte_link();
  ufc_out_if code_link();

  utf8_decode_case_fold_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (byte_link),
    .out_stream (code_link)
  );

  text_byte_t  byte_feed[$];
  decoded_t    due_results[$];
  int unsigned fault_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  logic        hold_request;

  // Sequence state of the predictor: bits gathered so far, continuations
  // still to come and bytes of the open sequence already taken.
  logic [CodeW-1:0] seq_bits;
  logic [1:0]       seq_left;
  logic [1:0]       seq_taken;

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  // Lower-case token form of a code point, or zero when it forms no token.
  function automatic logic [FoldW-1:0] token_fold(input logic [CodeW-1:0] c);
    int unsigned v;
    int unsigned f;
    v = 32'(c);
    if (v >= 'h41 && v <= 'h5A) begin
      f = v + 'h20;
    end else if ((v >= 'h61 && v <= 'h7A) || (v >= 'h30 && v <= 'h39)) begin
      f = v;
    end else if (v < 'hC0) begin
      f = 0;
    end else if (v <= 'hFF) begin
      // Latin-1: the two arithmetic signs sit among the letters.
      if (v == TimesSign || v == DivideSign) begin
        f = 0;
      end else begin
        f = (v <= 'hDE) ? v + 'h20 : v;
      end
    end else if (v == AlphaTonos) begin
      f = 'h3AC;
    end else if (v >= 'h388 && v <= 'h38A) begin
      f = v + 'h25;
    end else if (v == OmicronTonos) begin
      f = 'h3CC;
    end else if (v == 'h38E || v == 'h38F) begin
      f = v + 'h3F;
    end else if (v >= 'h391 && v <= 'h3AB) begin
      f = (v == GreekHole) ? 0 : v + 'h20;
    end else if (v >= 'h3AC && v <= 'h3CE) begin
      f = v;
    end else if (v >= 'h400 && v <= 'h40F) begin
      f = v + CyrExtShift;
    end else if (v >= 'h410 && v <= 'h42F) begin
      f = v + 'h20;
    end else if (v >= 'h430 && v <= 'h45F) begin
      f = v;
    end else if (v >= 'h460 && v <= 'h481) begin
      // Paired block with the capital on the even code point.
      f = v | 1;
    end else if (v == PalochkaUp) begin
      f = PalochkaLow;
    end else if (v >= 'h4C1 && v <= 'h4CE) begin
      // Here the capital sits on the odd code point.
      f = (v + 1) & ~1;
    end else if ((v >= 'h48A && v <= 'h4BF) || (v >= 'h4CF && v <= 'h4FF)) begin
      f = v | 1;
    end else begin
      f = 0;
    end
    return f[FoldW-1:0];
  endfunction

  function automatic decoded_t result_of(input logic [CodeW-1:0] c, input logic bad);
    decoded_t r;
    r.code = bad ? Replacement : c;
    r.fold = bad ? '0 : token_fold(c);
    r.bad  = bad;
    r.last = 1'b0;
    r.ends = 1'b0;
    return r;
  endfunction

  // Decodes one transferred byte and queues the results it must cause.
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    decoded_t    burst[$];
    logic        as_lead;
    int unsigned width;
    as_lead = 1'b1;
    if (seq_left != 0) begin
      if (b[7:6] == 2'b10) begin
        as_lead  = 1'b0;
        seq_bits = {seq_bits[CodeW-7:0], b[5:0]};
        seq_left = seq_left - 1'b1;
        if (seq_left == 0) begin
          burst = {burst, result_of(seq_bits, 1'b0)};
          seq_bits  = '0;
          seq_taken = '0;
        end else if (fin) begin
          // Truncated end: one replacement for every byte of the sequence.
          repeat (seq_taken + 1) burst = {burst, result_of('0, 1'b1)};
        end else begin
          seq_taken = seq_taken + 1'b1;
        end
      end else begin
        // A broken sequence gives up its held bytes; the byte then starts over.
        repeat (seq_taken) burst = {burst, result_of('0, 1'b1)};
      end
    end
    if (as_lead) begin
      seq_bits  = '0;
      seq_left  = '0;
      seq_taken = '0;
      if (b < 8'h80) begin
        burst = {burst, result_of({13'd0, b}, 1'b0)};
      end else if (b < LeadMin || b > LeadMax || fin) begin
        burst = {burst, result_of('0, 1'b1)};
      end else begin
        width     = (b >= 8'hF0) ? 4 : ((b >= 8'hE0) ? 3 : 2);
        seq_bits  = {13'd0, b & (8'hFF >> (width + 1))};
        seq_left  = 2'(width - 1);
        seq_taken = 2'd1;
      end
    end
    if (fin) begin
      seq_bits  = '0;
      seq_left  = '0;
      seq_taken = '0;
    end
    if (burst.size() != 0) begin
      burst[burst.size()-1].last = 1'b1;
      burst[burst.size()-1].ends = fin;
    end
    due_results = {due_results, burst};
  endtask

  // Byte driver: predicts every transfer as it happens, then offers the next
  // queued byte unless this cycle is chosen as a sender gap.
  always @(posedge clk) begin : drive_bytes
    text_byte_t nxt;
    if (rst) begin
      byte_link.valid <= 1'b0;
    end else begin
      if (byte_link.valid && byte_link.ready) begin
        decode_byte(byte_link.byte_in, byte_link.final_byte);
      end
      if (!byte_link.valid || byte_link.ready) begin
        if (byte_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = byte_feed.pop_front();
          byte_link.valid      <= 1'b1;
          byte_link.byte_in    <= nxt.value;
          byte_link.final_byte <= nxt.last_of_text;
        end else begin
          byte_link.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down in its own process.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_request) begin
      hold_left <= LongHold;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: every result transfer must match the oldest due result.
  always @(posedge clk) begin : check_results
    decoded_t got;
    decoded_t want;
    if (rst) begin
      code_link.ready <= 1'b0;
    end else begin
      code_link.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
      if (code_link.valid && code_link.ready) begin
        got.code = code_link.code_point;
        got.fold = code_link.folded;
        got.bad  = code_link.malformed;
        got.last = code_link.run_last;
        got.ends = code_link.text_end;
        if (due_results.size() == 0) begin
          if (fault_count < ShownFaults) begin
            $display("unexpected result: code %h fold %h bad %b last %b end %b",
                     got.code, got.fold, got.bad, got.last, got.ends);
          end
          fault_count++;
        end else begin
          want = due_results.pop_front();
          if (got.code !== want.code || got.fold !== want.fold || got.bad !== want.bad ||
              got.last !== want.last || got.ends !== want.ends) begin
            if (fault_count < ShownFaults) begin
              $display("mismatch: expected code %h fold %h bad %b last %b end %b",
                       want.code, want.fold, want.bad, want.last, want.ends);
              $display("          got      code %h fold %h bad %b last %b end %b",
                       got.code, got.fold, got.bad, got.last, got.ends);
            end
            fault_count++;
          end
        end
      end
    end
  end

  // Watchdog: too many cycles without a transfer on either channel.
  always @(posedge clk) begin
    if (rst || (byte_link.valid && byte_link.ready) || (code_link.valid && code_link.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic feed_byte(input logic [7:0] value, input logic last_of_text);
    text_byte_t t;
    t.value        = value;
    t.last_of_text = last_of_text;
    byte_feed = {byte_feed, t};
  endtask

  // Random text, mostly well-formed sequences of every length with the odd
  // stray byte or broken sequence. A text may end on any byte, so sequences
  // are sometimes cut short by the final flag.
  task automatic add_random_text(input int unsigned n_bytes);
    logic [7:0]  unit[$];
    int unsigned pushed;
    int unsigned kind;
    int unsigned cp;
    logic        fin;
    pushed = 0;
    while (pushed < n_bytes) begin
      unit.delete();
      kind = $urandom_range(99);
      if (kind < 35) begin
        unit = {unit, 8'($urandom_range(8'h7F))};
      end else if (kind < 63) begin
        // Two-byte forms; code points below 80 give the overlong C0 and C1 leads.
        cp = $urandom_range(1) ? $urandom_range('h0C0, 'h4FF) : $urandom_range('h7FF);
        unit = {unit, 8'hC0 | cp[10:6]};
        unit = {unit, 8'h80 | cp[5:0]};
      end else if (kind < 75) begin
        cp = $urandom_range('hFFFF);
        unit = {unit, 8'hE0 | cp[15:12]};
        unit = {unit, 8'h80 | cp[11:6]};
        unit = {unit, 8'h80 | cp[5:0]};
      end else if (kind < 84) begin
        unit = {unit, 8'($urandom_range(8'hF0, 8'hF4))};
        repeat (3) unit = {unit, 8'(8'h80 | ($urandom_range(255) & ContMask))};
      end else if (kind < 92) begin
        unit = {unit, 8'($urandom_range(255))};
      end else begin
        // A sequence interrupted by a byte that is no continuation.
        unit = {unit, 8'($urandom_range(LeadMin, LeadMax))};
        repeat ($urandom_range(2)) begin
          unit = {unit, 8'(8'h80 | ($urandom_range(255) & ContMask))};
        end
        unit = {unit, 8'($urandom_range(1) ? $urandom_range(8'h7F)
                                           : $urandom_range(8'hC0, 8'hFF))};
      end
      for (int i = 0; i < unit.size(); i++) begin
        fin = ($urandom_range(99) < 2) || (i == unit.size() - 1 && $urandom_range(99) < 5);
        feed_byte(unit[i], fin);
      end
      pushed += unit.size();
    end
  endtask

  // Waits until every queued byte has been transferred and every due result
  // has arrived, then lets the pipeline run dry.
  task automatic settle();
    do @(negedge clk);
    while (byte_feed.size() != 0 || byte_link.valid || due_results.size() != 0);
    repeat (TailTicks) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    sender_idle_pct    = tx_pct;
    receiver_stall_pct = rx_pct;
  endtask

  initial begin
    rst                  = 1'b1;
    byte_link.valid      = 1'b0;
    byte_link.byte_in    = '0;
    byte_link.final_byte = 1'b0;
    code_link.ready      = 1'b0;
    hold_request         = 1'b0;
    fault_count          = 0;
    quiet_cycles         = 0;
    seq_bits             = '0;
    seq_left             = '0;
    seq_taken            = '0;
    set_idling(0, 0);
    repeat (ResetTicks) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Opening text, no idling on either side.
    feed_byte(8'h00, 1'b0);                                  // smallest byte
    feed_byte(8'hC3, 1'b0); feed_byte(8'h89, 1'b0);          // Latin-1 capital
    feed_byte(8'hCE, 1'b0); feed_byte(8'h86, 1'b0);          // Greek capital with tonos
    feed_byte(8'hE0, 1'b0); feed_byte(8'h80, 1'b0);          // overlong NUL
    feed_byte(8'h80, 1'b0);
    feed_byte(8'hED, 1'b0); feed_byte(8'hA0, 1'b0);          // surrogate
    feed_byte(8'h80, 1'b0);
    feed_byte(8'hF4, 1'b0); feed_byte(8'hBF, 1'b0);          // beyond the Unicode range
    feed_byte(8'hBF, 1'b0); feed_byte(8'hBF, 1'b0);
    feed_byte(8'h80, 1'b0);                                  // stray continuation as lead
    feed_byte(8'hFF, 1'b0);                                  // byte that never leads
    feed_byte(8'hF0, 1'b0); feed_byte(8'h90, 1'b0);          // sequence cut by ASCII
    feed_byte(8'h41, 1'b0);
    feed_byte(8'hF0, 1'b0); feed_byte(8'h90, 1'b0);          // three held bytes, then a bad
    feed_byte(8'h80, 1'b0); feed_byte(8'hF5, 1'b0);          // lead: four replacements
    feed_byte(8'hE2, 1'b0); feed_byte(8'h82, 1'b1);          // text ends inside a sequence
    feed_byte(8'hC3, 1'b1);                                  // lead as the final byte
    add_random_text(80);
    settle();

    set_idling(86, 0);
    add_random_text(75);
    settle();

    set_idling(0, 86);
    add_random_text(75);
    settle();

    set_idling(12, 12);
    add_random_text(75);
    settle();

    // Receiver held off while the sender keeps offering bytes at full rate.
    set_idling(0, 0);
    hold_request = 1'b1;
    @(negedge clk);
    hold_request = 1'b0;
    add_random_text(60);
    settle();

    if (fault_count == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ufc_pkg.sv
rtl/core/ufc_in_if.sv
rtl/core/ufc_out_if.sv
rtl/core/ufc_decode.sv
rtl/core/ufc_emit.sv
rtl/core/utf8_decode_case_fold_core.sv
tb/tb_utf8_decode_case_fold_core.sv
